/* rtl/core/mds_pkg.sv */
// ----------------------------------------------------------------------------
// mds_pkg
// Shared types and constants for the maze depth-first exit search block.
// ----------------------------------------------------------------------------
`default_nettype none

package mds_pkg;

  // Grid store geometry
  localparam int MAX_ROWS   = 64;
  localparam int MAX_COLS   = 64;
  localparam int ROW_W      = 6;
  localparam int COL_W      = 6;
  localparam int POS_W      = ROW_W + COL_W;
  localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int DIM_W      = 7;
  localparam int CELL_W     = 4;

  // Pending-position stack
  localparam int STACK_DEPTH = 16384;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = SP_W + 1;

  // Stream payload widths
  localparam int ACT_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;

  // Cell codes
  localparam logic [CELL_W-1:0] CELL_OPEN    = 4'd1;
  localparam logic [CELL_W-1:0] CELL_VISITED = 4'd2;
  localparam logic [CELL_W-1:0] CELL_ENTRY   = 4'd5;
  localparam logic [CELL_W-1:0] CELL_EXIT    = 4'd9;

  // Configuration register indexes
  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_WRITE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_UNREACHABLE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NO_ENTRY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW    = 3'd4;

  // Controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_POP,
    S_POS,
    S_CHK,
    S_NBR,
    S_NTEST,
    S_MARK,
    S_FINISH
  } state_t;

  // Neighbor order
  typedef enum logic [1:0] {
    DIR_UP,
    DIR_DOWN,
    DIR_LEFT,
    DIR_RIGHT
  } dir_t;

  // Stack count operations
  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_ONE,
    CNT_DEC,
    CNT_INC,
    CNT_CLR
  } cnt_op_t;

  // Grid read address source
  typedef enum logic [1:0] {
    GRD_IN,
    GRD_STK,
    GRD_NBR
  } grd_sel_t;

  // Grid write source
  typedef enum logic {
    GWR_IN,
    GWR_MARK
  } gwr_sel_t;

  // Stack write source
  typedef enum logic {
    STK_ENTRY,
    STK_NBR
  } stk_sel_t;

  typedef struct packed {
    logic                grid_we;
    gwr_sel_t            gwr_sel;
    logic                grid_re;
    grd_sel_t            grd_sel;
    logic                stk_we;
    stk_sel_t            stk_sel;
    logic                stk_re;
    cnt_op_t             cnt_op;
    logic                pos_ld;
    logic                k_clr;
    logic                k_inc;
    logic                out_ld;
    logic [STATUS_W-1:0] out_status;
    logic                out_rd_grid;
  } mds_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_zero;
    logic cnt_full;
    logic entry_known;
    logic cell_exit;
    logic cell_pass;
    logic nbr_ok;
    logic k_last;
  } mds_sts_t;

endpackage

`default_nettype wire

/* rtl/core/mds_ctrl.sv */
// ----------------------------------------------------------------------------
// mds_ctrl
// Controller: sequences cell writes, reads and the depth-first search.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_ctrl
  import mds_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  input  wire logic [ACT_W-1:0] in_action,
  output logic                  in_tready,
  input  wire mds_sts_t         sts,
  output mds_cmd_t              cmd
);

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] fin_status_r, fin_status_nxt;
  logic                accept;

  assign in_tready = (state_r == S_IDLE) && sts.out_free;
  assign accept    = in_tvalid && in_tready;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fin_status_r <= ST_DONE;
    end else begin
      state_r      <= state_nxt;
      fin_status_r <= fin_status_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_action == ACT_READ) begin
            state_nxt = S_RDWAIT;
          end else if (in_action == ACT_SEARCH && sts.entry_known) begin
            state_nxt = S_POP;
          end
        end
      end
      S_RDWAIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_POP: begin
        state_nxt = sts.cnt_zero ? S_FINISH : S_POS;
      end
      S_POS: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = sts.cell_exit ? S_FINISH : S_NBR;
      end
      S_NBR: begin
        if (sts.nbr_ok) begin
          state_nxt = S_NTEST;
        end else if (sts.k_last) begin
          state_nxt = S_MARK;
        end
      end
      S_NTEST: begin
        if (sts.cell_pass && sts.cnt_full) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = sts.k_last ? S_MARK : S_NBR;
        end
      end
      S_MARK: state_nxt = S_POP;
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs
  always_comb begin
    cmd            = '0;
    cmd.gwr_sel    = GWR_IN;
    cmd.grd_sel    = GRD_IN;
    cmd.stk_sel    = STK_ENTRY;
    cmd.cnt_op     = CNT_HOLD;
    cmd.out_status = ST_DONE;
    fin_status_nxt = fin_status_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_WRITE: begin
              cmd.grid_we = 1'b1;
              cmd.out_ld  = 1'b1;
            end
            ACT_READ: begin
              cmd.grid_re = 1'b1;
            end
            ACT_SEARCH: begin
              if (sts.entry_known) begin
                cmd.stk_we = 1'b1;
                cmd.cnt_op = CNT_ONE;
              end else begin
                cmd.out_ld     = 1'b1;
                cmd.out_status = ST_NO_ENTRY;
              end
            end
            default: cmd.out_ld = 1'b1;
          endcase
        end
      end
      S_RDWAIT: begin
        cmd.out_ld      = sts.out_free;
        cmd.out_rd_grid = 1'b1;
      end
      S_POP: begin
        if (sts.cnt_zero) begin
          fin_status_nxt = ST_UNREACHABLE;
        end else begin
          cmd.stk_re = 1'b1;
          cmd.cnt_op = CNT_DEC;
        end
      end
      S_POS: begin
        cmd.grid_re = 1'b1;
        cmd.grd_sel = GRD_STK;
        cmd.pos_ld  = 1'b1;
      end
      S_CHK: begin
        if (sts.cell_exit) begin
          cmd.cnt_op     = CNT_CLR;
          fin_status_nxt = ST_FOUND;
        end else begin
          cmd.k_clr = 1'b1;
        end
      end
      S_NBR: begin
        if (sts.nbr_ok) begin
          cmd.grid_re = 1'b1;
          cmd.grd_sel = GRD_NBR;
        end else begin
          cmd.k_inc = !sts.k_last;
        end
      end
      S_NTEST: begin
        if (sts.cell_pass && sts.cnt_full) begin
          cmd.cnt_op     = CNT_CLR;
          fin_status_nxt = ST_OVERFLOW;
        end else begin
          if (sts.cell_pass) begin
            cmd.stk_we  = 1'b1;
            cmd.stk_sel = STK_NBR;
            cmd.cnt_op  = CNT_INC;
          end
          cmd.k_inc = !sts.k_last;
        end
      end
      S_MARK: begin
        cmd.grid_we = 1'b1;
        cmd.gwr_sel = GWR_MARK;
      end
      S_FINISH: begin
        cmd.out_ld     = sts.out_free;
        cmd.out_status = fin_status_r;
      end
      default: ;
    endcase
  end

  // Never overwrite a result still waiting for the receiver
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("result loaded while output register busy");

  // A popped exit empties the stack
  a_found_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHK && sts.cell_exit) |=> sts.cnt_zero)
    else $error("stack not cleared after exit found");

  // A search only starts with a recorded entry
  a_search_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && state_nxt == S_POP) |-> sts.entry_known)
    else $error("search started without entry");

endmodule

`default_nettype wire

/* rtl/core/mds_dp.sv */
// ----------------------------------------------------------------------------
// mds_dp
// Datapath: grid cell store, pending-position stack, neighbor address logic,
// configuration registers and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mds_dp
  import mds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [DIM_W-1:0]      cfg_data,
  // input item fields
  input  wire logic [ROW_W-1:0]      in_row,
  input  wire logic [COL_W-1:0]      in_col,
  input  wire logic [CELL_W-1:0]     in_cell_value,
  // control
  input  wire mds_cmd_t              cmd,
  output mds_sts_t                   sts,
  // result
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [STATUS_W-1:0]        out_status,
  output logic [CELL_W-1:0]          out_read_value
);

  logic [CELL_W-1:0] grid_mem [GRID_DEPTH];
  logic [POS_W-1:0]  stk_mem  [STACK_DEPTH];

  logic [DIM_W-1:0]    width_r, height_r;
  logic [ROW_W-1:0]    entry_row_r;
  logic [COL_W-1:0]    entry_col_r;
  logic                entry_known_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt, cnt_dec;
  logic [POS_W-1:0]    pos_r;
  dir_t                k_r;
  logic [CELL_W-1:0]   grid_rd_r;
  logic [POS_W-1:0]    stk_rd_r;
  logic                out_valid_r;
  logic [STATUS_W-1:0] status_r;
  logic [CELL_W-1:0]   rd_val_r;

  logic [DIM_W-1:0]    used_rows, used_cols;
  logic [DIM_W-1:0]    nr, nc, r7, c7;
  logic [POS_W-1:0]    nbr_pos, in_pos, grid_waddr, grid_raddr, stk_waddr_pos;
  logic [SP_W-1:0]     stk_waddr;
  logic [CELL_W-1:0]   grid_wdata;
  logic                out_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(MAX_COLS);
      height_r <= DIM_W'(MAX_ROWS);
    end else if (cfg_we) begin
      if (cfg_index == CFG_GRID_WIDTH) begin
        width_r <= cfg_data;
      end else begin
        height_r <= cfg_data;
      end
    end
  end

  // Clamp the grid in use to the store size
  assign used_rows = (height_r > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : height_r;
  assign used_cols = (width_r  > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : width_r;

  // Neighbor address: a step off row or column zero wraps high and fails the range test
  assign r7 = {1'b0, pos_r[POS_W-1:COL_W]};
  assign c7 = {1'b0, pos_r[COL_W-1:0]};
  always_comb begin
    nr = r7;
    nc = c7;
    case (k_r)
      DIR_UP:    nr = r7 - DIM_W'(1);
      DIR_DOWN:  nr = r7 + DIM_W'(1);
      DIR_LEFT:  nc = c7 - DIM_W'(1);
      DIR_RIGHT: nc = c7 + DIM_W'(1);
      default: ;
    endcase
  end
  assign nbr_pos = {nr[ROW_W-1:0], nc[COL_W-1:0]};
  assign in_pos  = {in_row, in_col};

  // Grid store address and data select
  assign grid_waddr = (cmd.gwr_sel == GWR_MARK) ? pos_r : in_pos;
  assign grid_wdata = (cmd.gwr_sel == GWR_MARK) ? CELL_VISITED : in_cell_value;
  always_comb begin
    case (cmd.grd_sel)
      GRD_STK: grid_raddr = stk_rd_r;
      GRD_NBR: grid_raddr = nbr_pos;
      default: grid_raddr = in_pos;
    endcase
  end

  // Grid store
  always_ff @(posedge clk) begin
    if (cmd.grid_we) grid_mem[grid_waddr] <= grid_wdata;
    if (cmd.grid_re) grid_rd_r <= grid_mem[grid_raddr];
  end

  // Record the entry on a write of the entry code
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_row_r   <= '0;
      entry_col_r   <= '0;
      entry_known_r <= 1'b0;
    end else if (cmd.grid_we && cmd.gwr_sel == GWR_IN && in_cell_value == CELL_ENTRY) begin
      entry_row_r   <= in_row;
      entry_col_r   <= in_col;
      entry_known_r <= 1'b1;
    end
  end

  // Stack store
  assign cnt_dec       = cnt_r - CNT_W'(1);
  assign stk_waddr     = (cmd.stk_sel == STK_NBR) ? cnt_r[SP_W-1:0] : '0;
  assign stk_waddr_pos = (cmd.stk_sel == STK_NBR) ? nbr_pos : {entry_row_r, entry_col_r};
  always_ff @(posedge clk) begin
    if (cmd.stk_we) stk_mem[stk_waddr] <= stk_waddr_pos;
    if (cmd.stk_re) stk_rd_r <= stk_mem[cnt_dec[SP_W-1:0]];
  end

  // Stack count
  always_comb begin
    case (cmd.cnt_op)
      CNT_ONE: cnt_nxt = CNT_W'(1);
      CNT_DEC: cnt_nxt = cnt_dec;
      CNT_INC: cnt_nxt = cnt_r + CNT_W'(1);
      CNT_CLR: cnt_nxt = '0;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Popped position and neighbor index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= DIR_UP;
    end else if (cmd.k_clr) begin
      k_r <= DIR_UP;
    end else if (cmd.k_inc) begin
      k_r <= dir_t'(k_r + 2'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pos_ld) pos_r <= stk_rd_r;
  end

  // Result register
  assign out_free = !out_valid_r || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      status_r <= cmd.out_status;
      rd_val_r <= cmd.out_rd_grid ? grid_rd_r : '0;
    end
  end

  assign out_tvalid     = out_valid_r;
  assign out_status     = status_r;
  assign out_read_value = rd_val_r;

  // Status back to the controller
  assign sts.out_free    = out_free;
  assign sts.cnt_zero    = (cnt_r == '0);
  assign sts.cnt_full    = (cnt_r == CNT_W'(STACK_DEPTH));
  assign sts.entry_known = entry_known_r;
  assign sts.cell_exit   = (grid_rd_r == CELL_EXIT);
  assign sts.cell_pass   = (grid_rd_r == CELL_OPEN) || (grid_rd_r == CELL_EXIT);
  assign sts.nbr_ok      = (nr < used_rows) && (nc < used_cols);
  assign sts.k_last      = (k_r == DIR_RIGHT);

  // Stack count stays within the stack
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  // No push into a full stack
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.stk_we && cmd.stk_sel == STK_NBR) |-> !sts.cnt_full)
    else $error("push into full stack");

  // Neighbor reads stay inside the grid in use
  a_nbr_read: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.grid_re && cmd.grd_sel == GRD_NBR) |-> sts.nbr_ok)
    else $error("neighbor read outside grid");

endmodule

`default_nettype wire

/* rtl/core/maze_dfs_exit_search.sv */
// ----------------------------------------------------------------------------
// maze_dfs_exit_search
// Maze grid store with a stack-based depth-first exit search.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ stream carries one command per transaction: write a cell, read a
//   cell, or run a search from the recorded entry. Every command returns one
//   transaction on the out_ stream with a status and, for reads, the cell code.
//   The user must set grid height and width on cfg_ only when idle (unchecked).
// Timing:
//   A cell write is taken once per cycle while out_tready stays high; its
//   result appears in the cycle after acceptance. A read goes through the
//   registered grid store read to the output register. A search steps
//   through pop, address, check, a test per neighbor and mark for each popped
//   cell, between a start and a finish step. The grid store serves the pops,
//   the neighbor tests and the visited marks in turn.
// Reset:
//   rst_n clears the controller, the stack count, the entry record and sets
//   the grid to 64 x 64. There is no clearing pass: cells must be written
//   before they are read or searched.
// Stalls:
//   A result waits in the output register while out_tready is low; the block
//   takes the next command only when that register is free or draining.
// ----------------------------------------------------------------------------
`default_nettype none

module maze_dfs_exit_search
  import mds_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [DIM_W-1:0]      cfg_data,
  // command stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // action, row, col, cell_value
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata   // status, read_value
);

  mds_cmd_t            cmd;
  mds_sts_t            sts;
  logic [ACT_W-1:0]    in_action;
  logic [ROW_W-1:0]    in_row;
  logic [COL_W-1:0]    in_col;
  logic [CELL_W-1:0]   in_cell_value;
  logic [STATUS_W-1:0] out_status;
  logic [CELL_W-1:0]   out_read_value;

  // Unpack the command fields
  assign in_action     = in_tdata[1:0];
  assign in_row        = in_tdata[7:2];
  assign in_col        = in_tdata[13:8];
  assign in_cell_value = in_tdata[17:14];

  // Pack the result fields
  assign out_tdata = {1'b0, out_read_value, out_status};

  mds_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_action),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mds_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_cell_value  (in_cell_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_status     (out_status),
    .out_read_value (out_read_value)
  );

endmodule

`default_nettype wire
